/* design/kct_pkg.sv */
package kct_pkg;

    localparam int KEY_W  = 32;
    localparam int CALL_W = 32;
    localparam int GRP_W  = 6;
    localparam int ACT_W  = 3;
    localparam int SLOT_W = 8;
    localparam int STAT_W = 2;

    localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_BY_KEY  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_BY_CALL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_HIGHER  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_LOWER   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_ADDED   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UPDATED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NONE    = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [CALL_W-1:0] call;
        logic [GRP_W-1:0]  grp;
    } entry_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [KEY_W-1:0]  key;
        logic [CALL_W-1:0] call;
        logic [GRP_W-1:0]  grp;
    } query_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [CALL_W-1:0] call_out;
        logic [STAT_W-1:0] status;
    } result_t;

endpackage

/* design/kct_cell.sv */
module kct_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            shift,
    input  kct_pkg::entry_t d,
    output kct_pkg::entry_t q
);
    import kct_pkg::*;

    entry_t ent_reg;

    // one table entry; moves one place toward the head when the ring turns
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg <= '0;
        end else if (shift) begin
            ent_reg <= d;
        end
    end

    assign q = ent_reg;

endmodule

/* design/kct_scan.sv */
module kct_scan #(
    parameter int ENTRIES = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             step,
    input  kct_pkg::query_t  qin,
    input  kct_pkg::entry_t  head,
    output kct_pkg::entry_t  tail,
    output logic             last,
    output kct_pkg::result_t res
);
    import kct_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    query_t            q_reg;
    logic [IW-1:0]     cnt_reg;
    logic [IW:0]       fill_reg, fill_next;
    logic              found_reg, found_next;
    logic              upd_reg, upd_next;
    logic              stop_reg, stop_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CALL_W-1:0] cout_reg, cout_next;
    logic [KEY_W-1:0]  best_reg, best_next;

    assign last = (cnt_reg == IW'(ENTRIES - 1));

    // head cell holds entry cnt_reg; its possibly rewritten value goes to the tail
    always_comb begin
        logic at_fill;
        logic grp_hit;
        at_fill    = ({1'b0, cnt_reg} == fill_reg);
        grp_hit    = (head.grp == q_reg.grp);
        tail       = head;
        fill_next  = fill_reg;
        found_next = found_reg;
        upd_next   = upd_reg;
        stop_next  = stop_reg;
        slot_next  = slot_reg;
        cout_next  = cout_reg;
        best_next  = best_reg;
        case (q_reg.action)
            ACT_INSERT: begin
                if (!found_reg && at_fill) begin
                    // no live match before the fill point: append here
                    tail.key   = q_reg.key;
                    tail.call  = q_reg.call;
                    tail.grp   = q_reg.grp;
                    found_next = 1'b1;
                    slot_next  = SLOT_W'(cnt_reg);
                    fill_next  = fill_reg + 1'b1;
                end else if (!found_reg && !stop_reg) begin
                    if (head.key == '0) begin
                        stop_next = 1'b1;
                    end else if (head.key == q_reg.key) begin
                        tail.call  = q_reg.call;
                        found_next = 1'b1;
                        upd_next   = 1'b1;
                        slot_next  = SLOT_W'(cnt_reg);
                    end
                end
            end
            ACT_BY_KEY: begin
                if (!found_reg && head.key == q_reg.key) begin
                    found_next = 1'b1;
                    slot_next  = SLOT_W'(cnt_reg);
                    cout_next  = head.call;
                end
            end
            ACT_BY_CALL: begin
                // ascending scan, last hit is the highest index
                if (head.call == q_reg.call) begin
                    found_next = 1'b1;
                    slot_next  = SLOT_W'(cnt_reg);
                end
            end
            ACT_HIGHER: begin
                if (grp_hit && head.key > q_reg.key
                        && (!found_reg || head.key < best_reg)) begin
                    found_next = 1'b1;
                    slot_next  = SLOT_W'(cnt_reg);
                    best_next  = head.key;
                end
            end
            ACT_LOWER: begin
                if (grp_hit && head.key < q_reg.key
                        && (!found_reg || head.key > best_reg)) begin
                    found_next = 1'b1;
                    slot_next  = SLOT_W'(cnt_reg);
                    best_next  = head.key;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            fill_reg  <= '0;
            found_reg <= 1'b0;
            upd_reg   <= 1'b0;
            stop_reg  <= 1'b0;
            slot_reg  <= '0;
            cout_reg  <= '0;
            best_reg  <= '0;
            q_reg     <= '0;
        end else if (start) begin
            q_reg     <= qin;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            upd_reg   <= 1'b0;
            stop_reg  <= 1'b0;
            slot_reg  <= '0;
            cout_reg  <= '0;
            best_reg  <= '0;
        end else if (step) begin
            cnt_reg   <= cnt_reg + 1'b1;
            fill_reg  <= fill_next;
            found_reg <= found_next;
            upd_reg   <= upd_next;
            stop_reg  <= stop_next;
            slot_reg  <= slot_next;
            cout_reg  <= cout_next;
            best_reg  <= best_next;
        end
    end

    always_comb begin
        res.found    = found_reg;
        res.slot     = slot_reg;
        res.call_out = cout_reg;
        res.status   = STAT_NONE;
        if (q_reg.action == ACT_INSERT) begin
            res.status = !found_reg ? STAT_FULL : (upd_reg ? STAT_UPDATED : STAT_ADDED);
        end
    end

endmodule

/* design/key_call_table_with_nearest_search.sv */
// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   action, key, call_word, group
// m_       out        m_valid / m_ready   found, slot, call_out, status
//
// Each item is handled by one full turn of the ring: the table is a
// ring of ENTRIES cells that turns one place a cycle past a single compare unit
// at its head, so every slot is seen once and lands back where it started.
// Inserts rewrite the head entry as it passes to the tail.
// Reset (aresetn low, synchronous) clears every cell and the fill count at once.
// A held result in the output register does not block the next scan; only the
// hand-off of a finished scan waits for the output register to free up.
module key_call_table_with_nearest_search #(
    parameter int ENTRIES = 256,
    parameter int GROUPS  = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [kct_pkg::ACT_W-1:0]   s_action,
    input  logic [kct_pkg::KEY_W-1:0]   s_key,
    input  logic [kct_pkg::CALL_W-1:0]  s_call_word,
    input  logic [kct_pkg::GRP_W-1:0]   s_group,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_found,
    output logic [kct_pkg::SLOT_W-1:0]  m_slot,
    output logic [kct_pkg::CALL_W-1:0]  m_call_out,
    output logic [kct_pkg::STAT_W-1:0]  m_status
);
    import kct_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t  state_reg, state_next;
    logic    m_valid_reg;
    result_t out_reg;

    query_t  qin;
    result_t res;
    entry_t  tail;
    entry_t  ring [ENTRIES];
    logic    start, step, last, out_load;
    logic [GRP_W-1:0] grp_fold [2**GRP_W];

    // group is folded into range before it is stored or compared; the fold
    // is a constant table over every group code
    for (genvar v = 0; v < 2**GRP_W; v++) begin : g_fold
        assign grp_fold[v] = GRP_W'(v % GROUPS);
    end

    assign qin.action = s_action;
    assign qin.key    = s_key;
    assign qin.call   = s_call_word;
    assign qin.grp    = grp_fold[s_group];

    assign s_ready  = (state_reg == ST_IDLE);
    assign start    = s_valid && s_ready;
    assign step     = (state_reg == ST_SCAN);
    assign out_load = (state_reg == ST_HOLD) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (start)    state_next = ST_SCAN;
            ST_SCAN: if (last)     state_next = ST_HOLD;
            ST_HOLD: if (out_load) state_next = ST_IDLE;
            default:               state_next = ST_IDLE;
        endcase
    end

    // ring of cells: each takes its upper neighbor, the top takes the head's
    // write-back value
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        entry_t d;
        if (i == ENTRIES - 1) begin : g_top
            assign d = tail;
        end else begin : g_mid
            assign d = ring[i+1];
        end
        kct_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift   (step),
            .d       (d),
            .q       (ring[i])
        );
    end

    kct_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .step    (step),
        .qin     (qin),
        .head    (ring[0]),
        .tail    (tail),
        .last    (last),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= res;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_found    = out_reg.found;
    assign m_slot     = out_reg.slot;
    assign m_call_out = out_reg.call_out;
    assign m_status   = out_reg.status;

endmodule

/* design/kct_checker.sv */
module kct_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_found,
    input logic [kct_pkg::SLOT_W-1:0]  m_slot,
    input logic [kct_pkg::CALL_W-1:0]  m_call_out,
    input logic [kct_pkg::STAT_W-1:0]  m_status
);
    import kct_pkg::*;

    // held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_slot) && $stable(m_status))
        else $error("result changed while stalled");

    // one item at a time: no accept right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while scan busy");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_FULL |-> !m_found)
        else $error("full insert reported found");

    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_slot == '0 && m_call_out == '0)
        else $error("miss with nonzero slot or call");

    a_call: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_call_out != '0 |-> m_found && m_status == STAT_NONE)
        else $error("call word on wrong action");

endmodule

bind key_call_table_with_nearest_search kct_checker u_kct_checker (.*);
